// ----- rtl/core/pixel_sample_variance_accumulator_top_defines.svh -----
// Assertion macros for the pixel sample variance accumulator
`ifndef PIXEL_SAMPLE_VARIANCE_ACCUMULATOR_TOP_DEFINES_SVH
`define PIXEL_SAMPLE_VARIANCE_ACCUMULATOR_TOP_DEFINES_SVH

// same-cycle implication
`define PSVA_ASSERT_SAME(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("psva check failed");

// next-cycle implication
`define PSVA_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("psva check failed");

`endif

// ----- rtl/core/psva_pkg.sv -----
// Package: types and constants of the pixel sample variance accumulator
`timescale 1ns / 1ps
package psva_pkg;
   localparam int MAX_WIDTH_DEF  = 64;
   localparam int MAX_HEIGHT_DEF = 64;
   localparam int DIV_W          = 48;

   typedef enum logic [1:0] {
      OP_ACC_RGB  = 2'd0,
      OP_ACC_MONO = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_QUERY    = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_RANGE = 2'd1,
      ST_SAT   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC,
      S_DIV,
      S_MUL,
      S_VAR,
      S_DONE
   } state_type;

   typedef enum logic {
      REG_WIDTH  = 1'b0,
      REG_HEIGHT = 1'b1
   } reg_type;

   typedef struct packed {
      logic [31:0] red_sum;
      logic [31:0] green_sum;
      logic [31:0] blue_sum;
      logic [47:0] red_sq;
      logic [47:0] green_sq;
      logic [47:0] blue_sq;
      logic [15:0] count;
   } entry_type;
endpackage

// ----- rtl/core/psva_store.sv -----
// Pixel state memory: one entry per pixel, one write and one registered read port
`timescale 1ns / 1ps
module psva_store #(
   parameter int DEPTH  = 4096,
   parameter int ADDR_W = 12
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_W-1:0]    wr_addr,
   input  psva_pkg::entry_type  wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_W-1:0]    rd_addr,
   output psva_pkg::entry_type  rd_data
);
   psva_pkg::entry_type mem [DEPTH];
   psva_pkg::entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/core/psva_div.sv -----
// Restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module psva_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [psva_pkg::DIV_W-1:0]    dividend,
   input  logic [15:0]                   divisor,
   output logic                          done,
   output logic [psva_pkg::DIV_W-1:0]    quotient
);
   localparam int CNT_W = $clog2(psva_pkg::DIV_W + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic [15:0]                rem_ff, rem_in;
   logic [psva_pkg::DIV_W-1:0] quo_ff, quo_in;
   logic [15:0]                dvs_ff, dvs_in;
   logic [16:0]                part;
   logic [16:0]                trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      part    = {rem_ff, quo_ff[psva_pkg::DIV_W-1]};
      trial   = part - {1'b0, dvs_ff};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(psva_pkg::DIV_W);
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         if (trial[16]) begin
            rem_in = part[15:0];
            quo_in = {quo_ff[psva_pkg::DIV_W-2:0], 1'b0};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[psva_pkg::DIV_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- rtl/core/pixel_sample_variance_accumulator_top.sv -----
// Pixel sample variance accumulator: control, register port and result stage
//
// Request channel (req_): one word per operation; op in tuser, pixel row, column and
// Q4.12 red, green, blue samples in tdata. Accumulate RGB, accumulate mono, clear
// pixel or query the largest per-channel variance of that pixel.
// Response channel (rsp_): one word per request, in order; signed Q8.24 variance and
// sample count in tdata, status in tuser (ok, out of range, count saturated).
// Config port (csr_): image width at 0x0, image height at 0x4, to be written by the user
// only while idle; the block itself does not enforce this.
// From acceptance, accumulate, clear and a query of an empty pixel pass through S_EXEC
// and S_DONE before rsp_tvalid rises; an out of range request goes straight to S_DONE.
// A query runs six 48-step divisions on the shared divider plus the square and compare
// steps. One request is in flight at a time; the next is accepted the cycle after the
// previous result loads the response register.
// Per-pixel state lives in one memory of MAX_WIDTH*MAX_HEIGHT entries with a registered
// read; the read is issued in the accept cycle. Reset: width and height return to 64,
// then a clearing pass zeroes every entry, one per cycle, with req_tready low.
// A stalled response holds its word; the block then takes at most one more request and
// holds its result until the response register drains.
`timescale 1ns / 1ps
module pixel_sample_variance_accumulator_top #(
   parameter int MAX_WIDTH  = psva_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = psva_pkg::MAX_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // row[5:0], col[11:6], red[27:12], green[43:28],
                                    // blue[59:44], zero[63:60]
   input  logic [1:0]  req_tuser,   // op[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // max_variance[32:0], sample_count[48:33], zero[55:49]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   psva_pkg::state_type  state_ff, state_in;
   logic [6:0]           width_ff, height_ff;
   logic [ADDR_W-1:0]    clr_ff, clr_in;
   logic [ADDR_W-1:0]    idx_ff, idx_in;
   psva_pkg::op_type     op_ff;
   logic [31:0]          sqr_ff, sqg_ff, sqb_ff;
   logic [15:0]          r_ff, g_ff, b_ff;
   logic [2:0]           step_ff, step_in;
   logic [15:0]          mean_ff, mean_in;
   logic [31:0]          msq_ff, msq_in;
   logic [31:0]          prod_ff;
   logic signed [33:0]   max_ff, max_in;
   logic [32:0]          var_ff, var_in;
   logic [15:0]          cnt_ff, cnt_in;
   psva_pkg::status_type st_ff, st_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [32:0]          rsp_var_ff;
   logic [15:0]          rsp_cnt_ff;
   psva_pkg::status_type rsp_st_ff;

   logic [6:0]           ew, eh;
   logic [5:0]           in_row, in_col;
   logic [15:0]          in_r, in_g, in_b;
   logic [12:0]          idx_raw;
   logic                 accept, bad;
   logic [15:0]          sel_g, sel_b;
   logic                 wr_en;
   logic [ADDR_W-1:0]    wr_addr;
   psva_pkg::entry_type  wr_data, rd_data;
   logic                 div_start, div_done;
   logic [psva_pkg::DIV_W-1:0] div_dividend, div_quo;
   logic signed [33:0]   var_now;
   logic                 csr_wr;

   // config registers
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 7'd64;
      end else if (csr_wr) begin
         unique case (psva_pkg::reg_type'(csr_paddr[2]))
            psva_pkg::REG_WIDTH:  width_ff  <= csr_pwdata[6:0];
            psva_pkg::REG_HEIGHT: height_ff <= csr_pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (psva_pkg::reg_type'(csr_paddr[2]))
         psva_pkg::REG_WIDTH:  csr_prdata = {25'd0, width_ff};
         psva_pkg::REG_HEIGHT: csr_prdata = {25'd0, height_ff};
         default:              csr_prdata = '0;
      endcase
   end

   // request decode
   assign ew      = (32'(width_ff) < MAX_WIDTH) ? width_ff : 7'(MAX_WIDTH);
   assign eh      = (32'(height_ff) < MAX_HEIGHT) ? height_ff : 7'(MAX_HEIGHT);
   assign in_row  = req_tdata[5:0];
   assign in_col  = req_tdata[11:6];
   assign in_r    = req_tdata[27:12];
   assign in_g    = req_tdata[43:28];
   assign in_b    = req_tdata[59:44];
   assign idx_raw = 13'(in_row) * 13'(ew) + 13'(in_col);
   assign bad     = ({1'b0, in_row} >= eh) || ({1'b0, in_col} >= ew);
   assign req_tready = (state_ff == psva_pkg::S_IDLE);
   assign accept  = req_tvalid & req_tready;
   assign idx_in  = ADDR_W'(idx_raw);
   assign sel_g   = (psva_pkg::op_type'(req_tuser) == psva_pkg::OP_ACC_MONO) ? in_r : in_g;
   assign sel_b   = (psva_pkg::op_type'(req_tuser) == psva_pkg::OP_ACC_MONO) ? in_r : in_b;

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff <= idx_in;
         op_ff  <= psva_pkg::op_type'(req_tuser);
         r_ff   <= in_r;
         g_ff   <= sel_g;
         b_ff   <= sel_b;
         sqr_ff <= in_r * in_r;
         sqg_ff <= sel_g * sel_g;
         sqb_ff <= sel_b * sel_b;
      end
   end

   psva_store #(.DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (idx_in),
      .rd_data (rd_data)
   );

   always_comb begin
      unique case (step_in)
         3'd0:    div_dividend = 48'(rd_data.red_sum);
         3'd1:    div_dividend = rd_data.red_sq;
         3'd2:    div_dividend = 48'(rd_data.green_sum);
         3'd3:    div_dividend = rd_data.green_sq;
         3'd4:    div_dividend = 48'(rd_data.blue_sum);
         default: div_dividend = rd_data.blue_sq;
      endcase
   end

   psva_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (rd_data.count),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign var_now = $signed({2'b00, msq_ff}) - $signed({2'b00, prod_ff});

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      step_in      = step_ff;
      mean_in      = mean_ff;
      msq_in       = msq_ff;
      max_in       = max_ff;
      var_in       = var_ff;
      cnt_in       = cnt_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = rd_data;
      div_start    = 1'b0;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         psva_pkg::S_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = psva_pkg::S_IDLE;
            end
         end
         psva_pkg::S_IDLE: begin
            if (accept) begin
               var_in = '0;
               cnt_in = '0;
               st_in  = psva_pkg::ST_RANGE;
               state_in = bad ? psva_pkg::S_DONE : psva_pkg::S_EXEC;
            end
         end
         psva_pkg::S_EXEC: begin
            var_in   = '0;
            st_in    = psva_pkg::ST_OK;
            state_in = psva_pkg::S_DONE;
            case (op_ff)
               psva_pkg::OP_ACC_RGB, psva_pkg::OP_ACC_MONO: begin
                  if (rd_data.count == 16'hFFFF) begin
                     cnt_in = 16'hFFFF;
                     st_in  = psva_pkg::ST_SAT;
                  end else begin
                     wr_en             = 1'b1;
                     wr_data.red_sum   = rd_data.red_sum + 32'(r_ff);
                     wr_data.green_sum = rd_data.green_sum + 32'(g_ff);
                     wr_data.blue_sum  = rd_data.blue_sum + 32'(b_ff);
                     wr_data.red_sq    = rd_data.red_sq + 48'(sqr_ff);
                     wr_data.green_sq  = rd_data.green_sq + 48'(sqg_ff);
                     wr_data.blue_sq   = rd_data.blue_sq + 48'(sqb_ff);
                     wr_data.count     = rd_data.count + 1'b1;
                     cnt_in            = rd_data.count + 1'b1;
                  end
               end
               psva_pkg::OP_CLEAR: begin
                  wr_en   = 1'b1;
                  wr_data = '0;
                  cnt_in  = '0;
               end
               default: begin
                  cnt_in = rd_data.count;
                  if (rd_data.count != 16'd0) begin
                     step_in   = 3'd0;
                     div_start = 1'b1;
                     state_in  = psva_pkg::S_DIV;
                  end
               end
            endcase
         end
         psva_pkg::S_DIV: begin
            if (div_done) begin
               if (!step_ff[0]) begin
                  mean_in   = (div_quo > 48'hFFFF) ? 16'hFFFF : div_quo[15:0];
                  step_in   = step_ff + 1'b1;
                  div_start = 1'b1;
               end else begin
                  msq_in   = (div_quo > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : div_quo[31:0];
                  state_in = psva_pkg::S_MUL;
               end
            end
         end
         psva_pkg::S_MUL: begin
            state_in = psva_pkg::S_VAR;
         end
         psva_pkg::S_VAR: begin
            if (step_ff == 3'd1 || var_now > max_ff) begin
               max_in = var_now;
            end
            if (step_ff == 3'd5) begin
               state_in = psva_pkg::S_DONE;
               var_in   = 33'((step_ff == 3'd1 || var_now > max_ff) ? var_now : max_ff);
            end else begin
               step_in   = step_ff + 1'b1;
               div_start = 1'b1;
               state_in  = psva_pkg::S_DIV;
            end
         end
         psva_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               state_in     = psva_pkg::S_IDLE;
            end
         end
         default: state_in = psva_pkg::S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psva_pkg::S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff <= step_in;
      mean_ff <= mean_in;
      msq_ff  <= msq_in;
      prod_ff <= mean_ff * mean_ff;
      max_ff  <= max_in;
      var_ff  <= var_in;
      cnt_ff  <= cnt_in;
      st_ff   <= st_in;
      if (state_ff == psva_pkg::S_DONE && (!rsp_valid_ff || rsp_tready)) begin
         rsp_var_ff <= var_ff;
         rsp_cnt_ff <= cnt_ff;
         rsp_st_ff  <= st_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_cnt_ff, rsp_var_ff};
   assign rsp_tuser  = rsp_st_ff;
endmodule

// ----- rtl/core/psva_checker.sv -----
// Port checker for the pixel sample variance accumulator, bound to the top level
`timescale 1ns / 1ps
`include "pixel_sample_variance_accumulator_top_defines.svh"
module psva_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   `PSVA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `PSVA_ASSERT_SAME(a_range_zero, clock, reset,
      rsp_tvalid && rsp_tuser == psva_pkg::ST_RANGE, rsp_tdata == 56'd0)
   `PSVA_ASSERT_SAME(a_sat_count, clock, reset,
      rsp_tvalid && rsp_tuser == psva_pkg::ST_SAT,
      rsp_tdata[48:33] == 16'hFFFF && rsp_tdata[32:0] == 33'd0)
   `PSVA_ASSERT_SAME(a_empty_var, clock, reset,
      rsp_tvalid && rsp_tdata[48:33] == 16'd0, rsp_tdata[32:0] == 33'd0)
endmodule

bind pixel_sample_variance_accumulator_top psva_checker u_psva_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ----- sim/pixel_sample_variance_accumulator_top_tb.sv -----
// Testbench: directed table and random operations on the pixel variance accumulator
`timescale 1ns / 1ps
module pixel_sample_variance_accumulator_top_tb;

   localparam int PIX_MAX = 64;
   localparam int DEPTH = PIX_MAX * PIX_MAX;
   localparam int N_RANDOM = 1550;
   localparam longint CYCLE_LIMIT = 3000000;

   typedef struct packed {
      psva_pkg::op_type op;
      logic [5:0]  row;
      logic [5:0]  col;
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
   } pixel_op_type;

   typedef struct packed {
      logic [32:0]          variance;
      logic [15:0]          count;
      psva_pkg::status_type status;
   } pixel_result_type;

   typedef struct {
      pixel_op_type     item;
      bit               fixed;
      pixel_result_type want;
   } table_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic [1:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        csr_psel = 0;
   logic        csr_penable = 0;
   logic        csr_pwrite = 0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   pixel_sample_variance_accumulator_top u_dut (.*);

   always #1 clock = ~clock;

   logic [31:0] red_acc [DEPTH];
   logic [31:0] green_acc [DEPTH];
   logic [31:0] blue_acc [DEPTH];
   logic [47:0] red_sq_acc [DEPTH];
   logic [47:0] green_sq_acc [DEPTH];
   logic [47:0] blue_sq_acc [DEPTH];
   logic [15:0] samples [DEPTH];
   logic [6:0]  width_reg = 64;
   logic [6:0]  height_reg = 64;

   pixel_result_type pending_results[$];
   bit failed = 0;
   bit quiet_tx = 0;
   bit quiet_rx = 0;
   longint cycles = 0;

   function automatic longint chan_variance(logic [31:0] s, logic [47:0] sq, logic [15:0] n);
      longint unsigned m, msq;
      if (n == 0) return 0;
      m = s / n;
      msq = sq / n;
      if (m > 64'hFFFF) m = 64'hFFFF;
      if (msq > 64'hFFFF_FFFF) msq = 64'hFFFF_FFFF;
      return longint'(msq) - longint'(m * m);
   endfunction

   function automatic pixel_result_type apply_op(pixel_op_type it);
      pixel_result_type r;
      int ew, eh, idx;
      longint v, vg, vb;
      logic [15:0] g, b;
      r.variance = '0;
      r.count = '0;
      r.status = psva_pkg::ST_OK;
      ew = (width_reg < PIX_MAX) ? width_reg : PIX_MAX;
      eh = (height_reg < PIX_MAX) ? height_reg : PIX_MAX;
      if (it.row >= eh || it.col >= ew) begin
         r.status = psva_pkg::ST_RANGE;
         return r;
      end
      idx = it.row * ew + it.col;
      case (it.op)
         psva_pkg::OP_ACC_RGB, psva_pkg::OP_ACC_MONO: begin
            if (samples[idx] == 16'hFFFF) begin
               r.count = 16'hFFFF;
               r.status = psva_pkg::ST_SAT;
               return r;
            end
            g = (it.op == psva_pkg::OP_ACC_MONO) ? it.red : it.green;
            b = (it.op == psva_pkg::OP_ACC_MONO) ? it.red : it.blue;
            red_acc[idx] += it.red;
            green_acc[idx] += g;
            blue_acc[idx] += b;
            red_sq_acc[idx] += 48'(it.red) * 48'(it.red);
            green_sq_acc[idx] += 48'(g) * 48'(g);
            blue_sq_acc[idx] += 48'(b) * 48'(b);
            samples[idx] += 1;
         end
         psva_pkg::OP_CLEAR: begin
            red_acc[idx] = 0; green_acc[idx] = 0; blue_acc[idx] = 0;
            red_sq_acc[idx] = 0; green_sq_acc[idx] = 0; blue_sq_acc[idx] = 0;
            samples[idx] = 0;
         end
         default: begin
            v = chan_variance(red_acc[idx], red_sq_acc[idx], samples[idx]);
            vg = chan_variance(green_acc[idx], green_sq_acc[idx], samples[idx]);
            vb = chan_variance(blue_acc[idx], blue_sq_acc[idx], samples[idx]);
            if (vg > v) v = vg;
            if (vb > v) v = vb;
            r.variance = v[32:0];
         end
      endcase
      r.count = samples[idx];
      return r;
   endfunction

   task automatic send_word(pixel_op_type it, bit fixed, pixel_result_type want);
      pixel_result_type p;
      while (!quiet_tx && $urandom_range(99) < 6) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      p = apply_op(it);
      if (fixed && p != want) begin
         $error("table row: max_variance expected %h predicted %h, sample_count expected %0d predicted %0d, status expected %0d predicted %0d",
                want.variance, p.variance, want.count, p.count, want.status, p.status);
         failed = 1;
      end
      pending_results.push_back(p);
      req_tvalid <= 1;
      req_tuser <= it.op;
      req_tdata <= {4'b0, it.blue, it.green, it.red, it.col, it.row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_reg(psva_pkg::reg_type r, logic [6:0] val);
      csr_psel <= 1; csr_pwrite <= 1; csr_penable <= 0;
      csr_paddr <= {r, 2'b00}; csr_pwdata <= {$urandom_range(1) ? 25'h1FFFFFF : 25'h0, val};
      @(posedge clock);
      csr_penable <= 1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 0; csr_penable <= 0; csr_pwrite <= 0;
      if (r == psva_pkg::REG_WIDTH) width_reg = val; else height_reg = val;
      @(posedge clock);
   endtask

   function automatic pixel_op_type rand_op(bit in_bounds);
      pixel_op_type it;
      int p, h, w;
      p = $urandom_range(99);
      it.op = p < 45 ? psva_pkg::OP_ACC_RGB : p < 65 ? psva_pkg::OP_ACC_MONO :
              p < 72 ? psva_pkg::OP_CLEAR : psva_pkg::OP_QUERY;
      if (in_bounds && width_reg != 0 && height_reg != 0) begin
         h = (height_reg > 64) ? 64 : height_reg;
         w = (width_reg > 64) ? 64 : width_reg;
         it.row = 6'($urandom_range(h - 1));
         it.col = 6'($urandom_range(w - 1));
         if ($urandom_range(3) == 0) begin
            it.row = {4'd0, it.row[1:0]};
            it.col = {4'd0, it.col[1:0]};
         end
      end else begin
         it.row = 6'($urandom);
         it.col = 6'($urandom);
      end
      it.red = 16'($urandom); it.green = 16'($urandom); it.blue = 16'($urandom);
      if ($urandom_range(3) == 0) it.red = $urandom_range(1) ? 16'hFFFF : 16'h0;
      return it;
   endfunction

   function automatic pixel_result_type res(logic [32:0] v, logic [15:0] c,
                                            psva_pkg::status_type s);
      pixel_result_type r;
      r.variance = v; r.count = c; r.status = s;
      return r;
   endfunction

   function automatic pixel_op_type mk(psva_pkg::op_type o, logic [5:0] r, logic [5:0] c,
                                       logic [15:0] rd, logic [15:0] gr, logic [15:0] bl);
      pixel_op_type it;
      it.op = o; it.row = r; it.col = c; it.red = rd; it.green = gr; it.blue = bl;
      return it;
   endfunction

   always @(posedge clock) begin
      pixel_result_type exp_r;
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("response word with nothing expected");
            failed = 1;
         end else begin
            exp_r = pending_results.pop_front();
            if (rsp_tdata[32:0] !== exp_r.variance) begin
               $error("max_variance expected %h actual %h", exp_r.variance, rsp_tdata[32:0]);
               failed = 1;
            end
            if (rsp_tdata[48:33] !== exp_r.count) begin
               $error("sample_count expected %0d actual %0d", exp_r.count, rsp_tdata[48:33]);
               failed = 1;
            end
            if (rsp_tuser !== exp_r.status) begin
               $error("status expected %0d actual %0d", exp_r.status, rsp_tuser);
               failed = 1;
            end
         end
      end
      rsp_tready <= quiet_rx || ($urandom_range(99) >= 6);
   end

   initial begin
      table_row_type tbl[$];
      pixel_op_type it;
      int k, ph;
      for (k = 0; k < DEPTH; k++) begin
         red_acc[k] = 0; green_acc[k] = 0; blue_acc[k] = 0;
         red_sq_acc[k] = 0; green_sq_acc[k] = 0; blue_sq_acc[k] = 0; samples[k] = 0;
      end
      repeat (4) @(posedge clock);
      reset <= 0;

      tbl.push_back('{mk(psva_pkg::OP_QUERY, 0, 0, 0, 0, 0), 1,
                      res(0, 0, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_QUERY, 63, 63, 16'hFFFF, 16'hFFFF, 16'hFFFF), 1,
                      res(0, 0, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_ACC_RGB, 63, 63, 16'hFFFF, 0, 16'hFFFF), 1,
                      res(0, 1, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_ACC_RGB, 63, 63, 0, 16'hFFFF, 0), 1,
                      res(0, 2, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_QUERY, 63, 63, 0, 0, 0), 0,
                      res(0, 0, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_ACC_MONO, 0, 1, 16'h1000, 16'hABCD, 16'h1234), 1,
                      res(0, 1, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_ACC_MONO, 0, 1, 16'h3000, 0, 0), 1,
                      res(0, 2, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_QUERY, 0, 1, 0, 0, 0), 0,
                      res(0, 0, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_ACC_RGB, 0, 1, 16'h0001, 16'h8000, 16'h7FFF), 1,
                      res(0, 3, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_QUERY, 0, 1, 0, 0, 0), 0,
                      res(0, 0, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_CLEAR, 0, 1, 0, 0, 0), 1,
                      res(0, 0, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_QUERY, 0, 1, 0, 0, 0), 1,
                      res(0, 0, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_ACC_RGB, 5, 6, 16'h5555, 16'hAAAA, 16'h5555), 1,
                      res(0, 1, psva_pkg::ST_OK)});
      tbl.push_back('{mk(psva_pkg::OP_QUERY, 5, 6, 0, 0, 0), 1,
                      res(0, 1, psva_pkg::ST_OK)});
      foreach (tbl[i]) send_word(tbl[i].item, tbl[i].fixed, tbl[i].want);
      drain_results();

      write_reg(psva_pkg::REG_WIDTH, 3);
      write_reg(psva_pkg::REG_HEIGHT, 2);
      send_word(mk(psva_pkg::OP_ACC_RGB, 2, 0, 1, 1, 1), 1, res(0, 0, psva_pkg::ST_RANGE));
      send_word(mk(psva_pkg::OP_QUERY, 0, 3, 1, 1, 1), 1, res(0, 0, psva_pkg::ST_RANGE));
      send_word(mk(psva_pkg::OP_ACC_RGB, 1, 2, 16'h2AAA, 16'h1555, 16'h0F0F), 0,
                res(0, 0, psva_pkg::ST_OK));
      send_word(mk(psva_pkg::OP_QUERY, 1, 2, 0, 0, 0), 0, res(0, 0, psva_pkg::ST_OK));
      drain_results();
      write_reg(psva_pkg::REG_WIDTH, 0);
      send_word(mk(psva_pkg::OP_ACC_RGB, 0, 0, 1, 1, 1), 1, res(0, 0, psva_pkg::ST_RANGE));
      drain_results();
      write_reg(psva_pkg::REG_WIDTH, 127);
      write_reg(psva_pkg::REG_HEIGHT, 0);
      send_word(mk(psva_pkg::OP_QUERY, 0, 0, 1, 1, 1), 1, res(0, 0, psva_pkg::ST_RANGE));
      drain_results();

      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin write_reg(psva_pkg::REG_WIDTH, 64);
                     write_reg(psva_pkg::REG_HEIGHT, 64); end
            1: begin write_reg(psva_pkg::REG_WIDTH, 1);
                     write_reg(psva_pkg::REG_HEIGHT, 1); end
            2: begin write_reg(psva_pkg::REG_WIDTH, 127);
                     write_reg(psva_pkg::REG_HEIGHT, 127); end
            3: begin write_reg(psva_pkg::REG_WIDTH, 7'($urandom_range(1, 64)));
                     write_reg(psva_pkg::REG_HEIGHT, 7'($urandom_range(1, 64))); end
            4: begin write_reg(psva_pkg::REG_WIDTH, 4);
                     write_reg(psva_pkg::REG_HEIGHT, 4); end
            default: begin write_reg(psva_pkg::REG_WIDTH, 64);
                           write_reg(psva_pkg::REG_HEIGHT, 0); end
         endcase
         quiet_tx = (ph == 2);
         quiet_rx = (ph == 2);
         for (k = 0; k < N_RANDOM / 6; k++) begin
            it = rand_op($urandom_range(9) != 0);
            send_word(it, 0, res(0, 0, psva_pkg::ST_OK));
            if (k == 100) drain_results();
         end
         drain_results();
      end

      if (!failed) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
